[design/epps_pkg.sv]
// shared types and constants of the encoder period pid speed controller
// no dependencies
`default_nettype none

package epps_pkg;

    // default depth of the elapsed-time history
    localparam int HISTORY_DEPTH_DEF = 3;

    // register indexes on the configuration port
    localparam logic [2:0] REG_GAIN_P   = 3'd0;
    localparam logic [2:0] REG_GAIN_I   = 3'd1;
    localparam logic [2:0] REG_GAIN_D   = 3'd2;
    localparam logic [2:0] REG_TARGET   = 3'd3;
    localparam logic [2:0] REG_INTERVAL = 3'd4;
    localparam logic [2:0] REG_UP_LEVEL = 3'd5;

    // integral clamp, two seconds in microseconds
    localparam logic signed [34:0] TOTAL_MAX = 35'sd2000000;
    localparam logic signed [34:0] TOTAL_MIN = -35'sd2000000;

    // drive saturation and accumulator width
    localparam int ACC_W = 40;
    localparam logic signed [ACC_W-1:0] DRIVE_MAX = 40'sd255;
    localparam logic signed [ACC_W-1:0] DRIVE_MIN = -40'sd255;

    // configuration register set
    typedef struct packed {
        logic [15:0] gain_p;
        logic [15:0] gain_i;
        logic [15:0] gain_d;
        logic [31:0] target;
        logic [31:0] interval;
        logic        up_level;
    } t_cfg;

    // commands from controller to datapath
    typedef struct packed {
        logic edge_cnt;
        logic latch;
        logic take;
        logic add;
        logic div_per;
        logic err;
        logic mul_p;
        logic mul_i;
        logic mul_d;
        logic acc_d;
        logic load_out;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic early;
        logic sum_last;
        logic div_busy;
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

[design/encoder_period_pid_speed.sv]
// encoder period measurement with pid drive: an edge transaction updates the count;
// an early tick is latched and dropped; a due tick is latched, summed over history,
// then one serial divide of the history sum by depth times count in the divider,
// error, pid products and accumulate, and a load into a free output register
// one transaction at a time; the output register holds a result while new ones enter
// synchronous active-low reset clears count, stamp, history, pid state and registers
// depends on epps_pkg, epps_ctrl, epps_dp, epps_div
`default_nettype none

module encoder_period_pid_speed #(
    parameter int HISTORY_DEPTH = epps_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_kind,
    input  wire logic               i_b_level,
    input  wire logic [31:0]        i_now_time,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [8:0]       o_drive,
    output logic signed [31:0]      o_period
);

    epps_pkg::t_cfg  r_cfg;
    epps_pkg::t_cmd  cmd;
    epps_pkg::t_stat stat;
    logic [2:0]      reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p   <= '0;
            r_cfg.gain_i   <= '0;
            r_cfg.gain_d   <= '0;
            r_cfg.target   <= '0;
            r_cfg.interval <= '0;
            r_cfg.up_level <= 1'b1;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                epps_pkg::REG_GAIN_P:   r_cfg.gain_p   <= pwdata[15:0];
                epps_pkg::REG_GAIN_I:   r_cfg.gain_i   <= pwdata[15:0];
                epps_pkg::REG_GAIN_D:   r_cfg.gain_d   <= pwdata[15:0];
                epps_pkg::REG_TARGET:   r_cfg.target   <= pwdata;
                epps_pkg::REG_INTERVAL: r_cfg.interval <= pwdata;
                epps_pkg::REG_UP_LEVEL: r_cfg.up_level <= pwdata[0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (reg_idx)
            epps_pkg::REG_GAIN_P:   prdata = {16'd0, r_cfg.gain_p};
            epps_pkg::REG_GAIN_I:   prdata = {16'd0, r_cfg.gain_i};
            epps_pkg::REG_GAIN_D:   prdata = {16'd0, r_cfg.gain_d};
            epps_pkg::REG_TARGET:   prdata = r_cfg.target;
            epps_pkg::REG_INTERVAL: prdata = r_cfg.interval;
            epps_pkg::REG_UP_LEVEL: prdata = {31'd0, r_cfg.up_level};
            default:                prdata = '0;
        endcase
    end

    epps_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    epps_dp #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_b_level  (i_b_level),
        .i_now_time (i_now_time),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_drive    (o_drive),
        .o_period   (o_period)
    );

endmodule

`default_nettype wire

[design/epps_div.sv]
// iterative restoring divider, one quotient bit per cycle
// no dependencies
`default_nettype none

module epps_div #(
    parameter int DW = 34
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [DW-1:0] i_divisor,
    output logic               o_busy,
    output logic               o_done,
    output logic [DW-1:0]      o_quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   trial;
    logic          fits;

    // shift in next dividend bit and test subtract
    assign trial = {r_rem, r_quo[DW-1]};
    assign fits  = trial >= {1'b0, r_dvs};

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], fits};
            r_rem <= fits ? DW'(trial - {1'b0, r_dvs}) : trial[DW-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

[design/epps_dp.sv]
// datapath: position count, time history, divider, pid multiply and output register
// depends on epps_pkg and epps_div
`default_nettype none

module epps_dp #(
    parameter int HISTORY_DEPTH = epps_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire epps_pkg::t_cfg     i_cfg,
    input  wire epps_pkg::t_cmd     i_cmd,
    output epps_pkg::t_stat         o_stat,
    input  wire logic               i_b_level,
    input  wire logic [31:0]        i_now_time,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [8:0]       o_drive,
    output logic signed [31:0]      o_period
);

    localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int SUM_W = 32 + $clog2(HISTORY_DEPTH);
    localparam int ACC_W = epps_pkg::ACC_W;

    logic [31:0]              r_count;
    logic [31:0]              r_last_stamp;
    logic [31:0]              r_now;
    logic [31:0]              r_elapsed;
    logic [31:0]              r_hist [HISTORY_DEPTH];
    logic [IDX_W-1:0]         r_slot;
    logic [IDX_W-1:0]         r_idx;
    logic [SUM_W-1:0]         r_sum;
    logic [31:0]              r_pos;
    logic signed [31:0]       r_per;
    logic signed [33:0]       r_err;
    logic signed [33:0]       r_last_err;
    logic signed [33:0]       r_total;
    logic signed [50:0]       r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_out_valid;
    logic signed [8:0]        r_out_drive;
    logic signed [31:0]       r_out_period;

    logic                     div_start;
    logic [SUM_W-1:0]         div_dividend;
    logic [SUM_W-1:0]         div_divisor;
    logic                     div_busy;
    logic                     div_done;
    logic [SUM_W-1:0]         div_quo;
    logic [31:0]              pos_abs;
    logic [31:0]              pos_sel;
    logic [31:0]              q32;
    logic signed [31:0]       n_per;
    logic signed [33:0]       n_err;
    logic signed [34:0]       total_sum;
    logic signed [33:0]       n_total;
    logic signed [15:0]       mul_a;
    logic signed [34:0]       mul_b;
    logic signed [ACC_W-1:0]  prod_shift;
    logic signed [8:0]        n_drive;
    logic                     out_free;

    // average and per-count division folded into one divide by depth times count
    assign pos_abs      = r_pos[31] ? 32'(~r_pos + 32'd1) : r_pos;
    assign pos_sel      = (r_pos == '0) ? 32'd1 : pos_abs;
    assign div_start    = i_cmd.div_per;
    assign div_dividend = r_sum;
    assign div_divisor  = SUM_W'(pos_sel) * SUM_W'(HISTORY_DEPTH);

    epps_div #(.DW(SUM_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // signed period with saturation, error and clamped integral
    assign q32 = div_quo[31:0];
    always_comb begin
        if (r_pos[31]) begin
            n_per = (q32 > 32'h8000_0000) ? 32'sh8000_0000 : $signed(32'(~q32 + 32'd1));
        end else begin
            n_per = q32[31] ? 32'sh7FFF_FFFF : $signed(q32);
        end
        n_err     = 34'(n_per) - $signed({2'b00, i_cfg.target});
        total_sum = 35'(r_total) + 35'(n_err);
        if (total_sum > epps_pkg::TOTAL_MAX) begin
            n_total = 34'(epps_pkg::TOTAL_MAX);
        end else if (total_sum < epps_pkg::TOTAL_MIN) begin
            n_total = 34'(epps_pkg::TOTAL_MIN);
        end else begin
            n_total = total_sum[33:0];
        end
    end

    // shared multiplier operands
    always_comb begin
        if (i_cmd.mul_i) begin
            mul_a = $signed(i_cfg.gain_i);
            mul_b = 35'(r_total);
        end else if (i_cmd.mul_d) begin
            mul_a = $signed(i_cfg.gain_d);
            mul_b = 35'(r_err) - 35'(r_last_err);
        end else begin
            mul_a = $signed(i_cfg.gain_p);
            mul_b = 35'(r_err);
        end
    end

    // floor shift of the last product
    assign prod_shift = ACC_W'(r_prod >>> 16);

    // drive saturation
    always_comb begin
        if (r_acc > epps_pkg::DRIVE_MAX) begin
            n_drive = 9'sd255;
        end else if (r_acc < epps_pkg::DRIVE_MIN) begin
            n_drive = -9'sd255;
        end else begin
            n_drive = r_acc[8:0];
        end
    end

    assign out_free = !r_out_valid || !i_stall;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_last_stamp <= '0;
            r_slot       <= '0;
            r_idx        <= '0;
            r_last_err   <= '0;
            r_total      <= '0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                r_hist[i] <= '0;
            end
        end else begin
            if (i_cmd.edge_cnt) begin
                r_count <= (i_b_level == i_cfg.up_level) ? r_count + 32'd1 : r_count - 32'd1;
            end
            if (i_cmd.take) begin
                r_count       <= '0;
                r_hist[r_slot] <= r_elapsed;
                r_slot        <= (r_slot == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : r_slot + 1'b1;
                r_idx         <= '0;
                if (r_count != '0) begin
                    r_last_stamp <= r_now;
                end
            end
            if (i_cmd.add) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.err) begin
                r_total <= n_total;
            end
            if (i_cmd.acc_d) begin
                r_last_err <= r_err;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_now     <= i_now_time;
            r_elapsed <= i_now_time - r_last_stamp;
        end
        if (i_cmd.take) begin
            r_pos <= r_count;
            r_sum <= '0;
        end
        if (i_cmd.add) begin
            r_sum <= r_sum + SUM_W'(r_hist[r_idx]);
        end
        if (i_cmd.err) begin
            r_per <= n_per;
            r_err <= n_err;
        end
        if (i_cmd.mul_p || i_cmd.mul_i || i_cmd.mul_d) begin
            r_prod <= 51'(mul_a) * 51'(mul_b);
        end
        if (i_cmd.mul_i) begin
            r_acc <= prod_shift;
        end else if (i_cmd.mul_d || i_cmd.acc_d) begin
            r_acc <= r_acc + prod_shift;
        end
        if (i_cmd.load_out) begin
            r_out_drive  <= n_drive;
            r_out_period <= r_per;
        end
    end

    assign o_stat.early    = r_elapsed < i_cfg.interval;
    assign o_stat.sum_last = r_idx == IDX_W'(HISTORY_DEPTH - 1);
    assign o_stat.div_busy = div_busy;
    assign o_stat.div_done = div_done;
    assign o_stat.out_free = out_free;

    assign o_valid  = r_out_valid;
    assign o_drive  = r_out_drive;
    assign o_period = r_out_period;

endmodule

`default_nettype wire

[design/epps_ctrl.sv]
// controller state machine sequencing one control update
// depends on epps_pkg
`default_nettype none

module epps_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic            i_kind,
    output logic                 o_stall,
    input  wire epps_pkg::t_stat i_stat,
    output epps_pkg::t_cmd       o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_SUM   = 4'd2;
    localparam logic [3:0] S_DIVB  = 4'd3;
    localparam logic [3:0] S_WAITB = 4'd4;
    localparam logic [3:0] S_ERR   = 4'd5;
    localparam logic [3:0] S_MP    = 4'd6;
    localparam logic [3:0] S_MI    = 4'd7;
    localparam logic [3:0] S_MD    = 4'd8;
    localparam logic [3:0] S_ACC   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       accept;

    assign o_stall = r_state != S_IDLE;
    assign accept  = i_valid && (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.edge_cnt = !i_kind;
                    o_cmd.latch    = i_kind;
                    if (i_kind) n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.early) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.take = 1'b1;
                    n_state    = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.add = 1'b1;
                if (i_stat.sum_last) n_state = S_DIVB;
            end
            S_DIVB: begin
                o_cmd.div_per = 1'b1;
                n_state       = S_WAITB;
            end
            S_WAITB: begin
                if (i_stat.div_done) n_state = S_ERR;
            end
            S_ERR: begin
                o_cmd.err = 1'b1;
                n_state   = S_MP;
            end
            S_MP: begin
                o_cmd.mul_p = 1'b1;
                n_state     = S_MI;
            end
            S_MI: begin
                o_cmd.mul_i = 1'b1;
                n_state     = S_MD;
            end
            S_MD: begin
                o_cmd.mul_d = 1'b1;
                n_state     = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc_d = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef NO_ASSERTIONS
    // result only loads into a free output register
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_stat.out_free) else $error("output overwritten");

    // divider never restarted while running
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_per |-> !i_stat.div_busy)
        else $error("divider restarted while busy");

    // a due tick goes on to the history sum
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK && !i_stat.early) |=> (r_state == S_SUM))
        else $error("due tick not taken");

    // divider busy on entering the wait after its start
    a_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVB) |=> i_stat.div_busy) else $error("divider not started");
`endif

endmodule

`default_nettype wire

[test/tb_top.sv]
// testbench for the encoder period pid speed controller: apb register setup,
// random edge and tick transactions, scoreboard prediction and result checking
// depends on epps_pkg and encoder_period_pid_speed
`default_nettype none

class speed_scoreboard;
    // register copy
    logic signed [15:0] kp, ki, kd;
    logic [31:0] target, interval;
    logic up_level;
    // controller state copy
    logic [31:0] count, stamp;
    logic [31:0] hist [3];
    int slot;
    longint last_err, err_total;
    // expected results
    logic signed [8:0] exp_drive [$];
    logic signed [31:0] exp_period [$];
    int errors;

    function new();
        kp = 0; ki = 0; kd = 0; target = 0; interval = 0; up_level = 1;
        count = 0; stamp = 0; slot = 0; last_err = 0; err_total = 0;
        foreach (hist[i]) hist[i] = 0;
        errors = 0;
    endfunction

    function longint floor16(longint x);
        return x >>> 16;
    endfunction

    function longint clip(longint x, longint lo, longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    // note an accepted input transaction
    function void note_input(logic kind, logic b, logic [31:0] now);
        logic [31:0] elapsed;
        longint pos, sum, avg, per, err, dsum;
        if (!kind) begin
            if (b == up_level) count = count + 1;
            else count = count - 1;
            return;
        end
        elapsed = now - stamp;
        if (elapsed < interval) return;
        pos = longint'($signed(count));
        count = 0;
        if (pos != 0) stamp = now;
        hist[slot] = elapsed;
        slot = (slot + 1) % 3;
        sum = longint'(hist[0]) + longint'(hist[1]) + longint'(hist[2]);
        avg = sum / 3;
        per = clip(avg / (pos == 0 ? 1 : pos), -64'sd2147483648, 64'sd2147483647);
        err = per - longint'(target);
        err_total = clip(err_total + err, -2000000, 2000000);
        dsum = floor16(longint'(kp) * err) + floor16(longint'(kd) * (err - last_err))
             + floor16(longint'(ki) * err_total);
        last_err = err;
        exp_drive.push_back(9'(clip(dsum, -255, 255)));
        exp_period.push_back(32'(per));
    endfunction

    function void report(string what);
        $display("mismatch: %s", what);
        errors++;
    endfunction

    // check one accepted result against the oldest expectation
    function void check_result(logic signed [8:0] drive, logic signed [31:0] period);
        logic signed [8:0] ed;
        logic signed [31:0] ep;
        if (exp_drive.size() == 0) begin
            report("result with nothing expected");
            return;
        end
        ed = exp_drive.pop_front();
        ep = exp_period.pop_front();
        if (drive !== ed) report($sformatf("drive %0d expected %0d", drive, ed));
        if (period !== ep) report($sformatf("period %0d expected %0d", period, ep));
    endfunction
endclass

module tb_top;

    logic i_clk = 0, i_rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [4:0] paddr = 0;
    logic [31:0] pwdata = 0, prdata;
    logic pready;
    logic i_valid = 0, o_stall;
    logic i_kind = 0, i_b_level = 0;
    logic [31:0] i_now_time = 0;
    logic o_valid, i_stall = 0;
    logic signed [8:0] o_drive;
    logic signed [31:0] o_period;

    speed_scoreboard sb;
    longint cycles = 0;
    logic out_done = 0;
    logic [31:0] clock_now = 0;

    encoder_period_pid_speed u_dut (.*);

    always #2 i_clk = ~i_clk;

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // output side: random stalls, check every accepted result
    initial begin
        int w;
        @(posedge i_clk);
        while (!out_done) begin
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            if (w > 0) begin
                i_stall <= 1;
                repeat (w) @(posedge i_clk);
                i_stall <= 0;
            end
            do begin
                @(posedge i_clk);
                if (o_valid && !i_stall) sb.check_result(o_drive, o_period);
            end while (!(o_valid && !i_stall) && !out_done);
        end
    end

    // register write over apb, mirrored in the scoreboard copy, with an idle gap after it
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            epps_pkg::REG_GAIN_P:   sb.kp = val[15:0];
            epps_pkg::REG_GAIN_I:   sb.ki = val[15:0];
            epps_pkg::REG_GAIN_D:   sb.kd = val[15:0];
            epps_pkg::REG_TARGET:   sb.target = val;
            epps_pkg::REG_INTERVAL: sb.interval = val;
            epps_pkg::REG_UP_LEVEL: sb.up_level = val[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // one input transaction with a random lead-in gap; valid stays up until the next gap
    task automatic send_item(logic kind, logic b, logic [31:0] now, bit gaps);
        int w;
        w = gaps ? $urandom_range(0, 17) : 0;
        if (gaps && $urandom_range(0, 3) == 0) w = 0;
        if (w > 0) begin
            i_valid <= 0;
            repeat (w) @(posedge i_clk);
        end
        i_valid <= 1; i_kind <= kind; i_b_level <= b; i_now_time <= now;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(kind, b, now);
    endtask

    // wait for all results, then for a trailing stretch
    task automatic drain();
        i_valid <= 0;
        while (sb.exp_drive.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic run_random(int n);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 9);
            if (k < 7) begin
                send_item(0, ($urandom_range(0, 9) < 8) ? sb.up_level : ~sb.up_level,
                          $urandom, 1);
            end else begin
                clock_now = clock_now + $urandom_range(0, 3 * sb.interval / 2 + 50);
                if ($urandom_range(0, 19) == 0) clock_now = $urandom;
                send_item(1, $urandom_range(0, 1), clock_now, 1);
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: defaults, extreme gains, direction both ways, zero count
        send_item(0, 1, 0, 0);
        send_item(0, 0, 32'hFFFFFFFF, 0);
        send_item(0, 1, 0, 0);
        send_item(1, 0, 32'd1000, 0);
        send_item(1, 1, 32'd1000, 0);
        drain();
        write_reg(epps_pkg::REG_GAIN_P, 32'h7FFF);
        write_reg(epps_pkg::REG_GAIN_I, 32'hFFFF8000);
        write_reg(epps_pkg::REG_GAIN_D, 32'h0100);
        write_reg(epps_pkg::REG_TARGET, 32'hFFFFFFFF);
        write_reg(epps_pkg::REG_INTERVAL, 32'd500);
        write_reg(epps_pkg::REG_UP_LEVEL, 0);
        send_item(1, 0, 32'd100, 0);
        send_item(0, 0, 0, 0);
        send_item(0, 0, 0, 0);
        send_item(1, 0, 32'd2000, 0);
        send_item(0, 1, 0, 0);
        send_item(0, 1, 0, 0);
        send_item(0, 1, 0, 0);
        send_item(1, 0, 32'hFFFFFFF0, 0);
        send_item(1, 1, 32'h00000100, 0);
        send_item(0, 0, 0, 0);
        send_item(1, 0, 32'h80000000, 0);
        drain();

        // random phases over several settings
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(epps_pkg::REG_GAIN_P, (ph == 1) ? 32'h8000 : $urandom);
            write_reg(epps_pkg::REG_GAIN_I, (ph == 2) ? 32'h7FFF : $urandom_range(0, 65535));
            write_reg(epps_pkg::REG_GAIN_D, (ph == 3) ? 32'h8000 : $urandom);
            write_reg(epps_pkg::REG_TARGET, (ph == 4) ? 32'd0 : $urandom_range(0, 20000));
            write_reg(epps_pkg::REG_INTERVAL, (ph == 5) ? 32'd0 :
                      (ph == 6) ? 32'hFFFFFFFF : $urandom_range(1, 5000));
            write_reg(epps_pkg::REG_UP_LEVEL, $urandom_range(0, 1));
            clock_now = sb.stamp;
            run_random(250);
            drain();
        end

        out_done = 1;
        repeat (4) @(posedge i_clk);
        if (sb.errors == 0 && sb.exp_drive.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

`default_nettype wire

[files.f]
design/epps_pkg.sv
design/epps_div.sv
design/epps_dp.sv
design/epps_ctrl.sv
design/encoder_period_pid_speed.sv
test/tb_top.sv
